### sv/stack_with_max_core_assert.svh
// ----------------------------------------------------------------------------
// stack_with_max_core_assert.svh - assertion macros
// Implication and next-cycle checks, clocked and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MAX_CORE_ASSERT_SVH
`define STACK_WITH_MAX_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack_with_max_core: same-cycle check failed");

// Next-cycle implication
`define SWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack_with_max_core: next-cycle check failed");

`else

`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg - shared types and constants of the max-tracking stack
// Depth, counter width, entry layout, shift controls and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One stack entry: stored value and maximum of it and all entries below
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] run_max;
  } swm_entry_t;

  // Shift controls shared by every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } swm_shift_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } swm_status_t;

endpackage

`default_nettype wire

### sv/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell - one slot of the shifting stack
// Takes the entry above on a push and the entry below on a pop, else holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
  input  wire                 clk,
  input  swm_pkg::swm_shift_t shift,
  input  swm_pkg::swm_entry_t from_above,
  input  swm_pkg::swm_entry_t from_below,
  output swm_pkg::swm_entry_t q
);

  swm_pkg::swm_entry_t entry_r;

  // Move down on push, up on pop
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry_r <= from_above;
    end else if (shift.pop) begin
      entry_r <= from_below;
    end
  end

  assign q = entry_r;

endmodule

`default_nettype wire

### sv/stack_with_max_core.sv
// ----------------------------------------------------------------------------
// stack_with_max_core - bounded LIFO stack reporting its largest value
// A chain of shifting cells holds the entries, top in cell 0; each entry
// carries the running maximum, so every request touches only the top cells.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser
// in_      in   push_value[31:0]                            mode (0 push, 1 pop)
// out_     out  popped_value, current_max, is_empty, pad    status[1:0]
//
// One request per cycle while the output is drained: the chain shifts in the
// accept cycle and the result sits in the output register from the next cycle on.
// Throughput is set by the single output register; in_tready is high while it
// is empty or being drained.
// Reset (rst_n low, synchronous) empties the stack and the output register
// and holds in_tready low; cell contents are left as they are and never read
// while unused.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stack_with_max_core_assert.svh"

module stack_with_max_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] push_value
  input  wire  [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // [31:0] popped_value, [63:32] current_max,
                                  // [64] is_empty, [71:65] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int DEPTH = swm_pkg::STACK_DEPTH;
  localparam int CW    = swm_pkg::CNT_W;
  localparam int DW    = swm_pkg::DATA_W;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] popped_r, popped_nxt;
  logic signed [DW-1:0] max_r, max_nxt;
  logic                 empty_r, empty_nxt;
  swm_pkg::swm_status_t status_r, status_nxt;

  logic                 accept;
  logic                 is_pop;
  logic                 stack_empty;
  logic                 stack_full;
  logic                 ovf_shown;
  logic signed [DW-1:0] push_value;
  logic signed [DW-1:0] new_max;
  swm_pkg::swm_shift_t  shift;
  swm_pkg::swm_entry_t  new_entry;
  swm_pkg::swm_entry_t  cell_q [DEPTH];

  assign in_tready   = rst_n && (!out_valid_r || out_tready);
  assign accept      = in_tvalid && in_tready;
  assign is_pop      = in_tuser[0];
  assign push_value  = $signed(in_tdata);
  assign stack_empty = (cnt_r == '0);
  assign stack_full  = (cnt_r == CW'(DEPTH));

  // Running maximum of the entry about to be pushed
  assign new_max = (stack_empty || (push_value > cell_q[0].run_max))
                   ? push_value : cell_q[0].run_max;
  assign new_entry.value   = push_value;
  assign new_entry.run_max = new_max;

  assign shift.push = accept && !is_pop && !stack_full;
  assign shift.pop  = accept && is_pop && !stack_empty;

  // Chain of cells, top of stack in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swm_pkg::swm_entry_t above, below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    swm_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  // Next count and result
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    popped_nxt    = popped_r;
    max_nxt       = max_r;
    empty_nxt     = empty_r;
    status_nxt    = status_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = '0;
      if (is_pop) begin
        if (stack_empty) begin
          max_nxt    = swm_pkg::INT_MIN;
          empty_nxt  = 1'b1;
          status_nxt = swm_pkg::ST_UNDERFLOW;
        end else begin
          cnt_nxt    = cnt_r - CW'(1);
          popped_nxt = cell_q[0].value;
          empty_nxt  = (cnt_r == CW'(1));
          max_nxt    = (cnt_r == CW'(1)) ? swm_pkg::INT_MIN : cell_q[1].run_max;
          status_nxt = swm_pkg::ST_OK;
        end
      end else begin
        empty_nxt = 1'b0;
        if (stack_full) begin
          max_nxt    = cell_q[0].run_max;
          status_nxt = swm_pkg::ST_OVERFLOW;
        end else begin
          cnt_nxt    = cnt_r + CW'(1);
          max_nxt    = new_max;
          status_nxt = swm_pkg::ST_OK;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    max_r    <= max_nxt;
    empty_r  <= empty_nxt;
    status_r <= status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, empty_r, max_r, popped_r};
  assign out_tuser  = status_r;

  // Overflow result waiting at the output
  assign ovf_shown = out_valid_r && (status_r == swm_pkg::ST_OVERFLOW);

  // Checks
  `SWM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `SWM_ASSERT_IMP(a_empty_flag, clk, rst_n, out_valid_r, empty_r == (cnt_r == '0))
  `SWM_ASSERT_IMP(a_ovf_full, clk, rst_n, ovf_shown, cnt_r == CW'(DEPTH))
  `SWM_ASSERT_NXT(a_push_cnt, clk, rst_n, shift.push, cnt_r == $past(cnt_r) + CW'(1))

endmodule

`default_nettype wire
